FILE: src/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the sphere patch generator.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is held.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Invariant checked on every rising edge, off while reset is held.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`endif

FILE: src/spvg_pkg.sv
// ------------------------------------------------------------------------
// spvg_pkg
// Types, codes and constants shared by the sphere patch generator.
// ------------------------------------------------------------------------
`default_nettype none

package spvg_pkg;

  localparam int DIAM_W = 16;
  localparam int DIVS_W = 9;
  localparam int COL_W  = 8;
  localparam int BAND_W = 8;
  localparam int RING_W = 9;
  localparam int TEX_W  = 17;
  localparam int NUM_W  = 41;
  localparam int CS_W   = 34;
  localparam int SQRT_STEPS = 16;

  localparam logic [1:0] ACT_TOP = 2'd0;
  localparam logic [1:0] ACT_MID = 2'd1;
  localparam logic [1:0] ACT_BOT = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

  localparam logic [DIAM_W-1:0] DIAMETER_RST = 16'd256;
  localparam logic [DIVS_W-1:0] RADIAL_RST   = 9'd16;
  localparam logic [DIVS_W-1:0] HEIGHT_RST   = 9'd16;

  localparam logic [31:0]         PI_Q30   = 32'd3373259426;
  localparam logic signed [CS_W-1:0] CORDIC_K = 34'sd652032874;
  localparam logic [TEX_W-1:0]    TEX_ONE  = 17'd65536;

  typedef enum logic [1:0] {
    KIND_TOP,
    KIND_MID,
    KIND_BOT,
    KIND_ERR
  } kind_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [COL_W-1:0]  column;
    logic [BAND_W-1:0] band;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] pos_z;
    logic [TEX_W-1:0]   tex_s;
    logic [TEX_W-1:0]   tex_t;
    logic               last;
    logic               error;
  } out_item_t;

  typedef struct packed {
    logic [DIAM_W-1:0] diameter;
    logic [DIVS_W-1:0] radial_divisions;
    logic [DIVS_W-1:0] height_divisions;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [COL_W-1:0]  column;
    logic [RING_W-1:0] ring;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DIVS_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  // atan(2^-i) in radians, Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000008;
      5'd28: v = 30'h00000004;
      5'd29: v = 30'h00000002;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: src/spvg_front.sv
// ------------------------------------------------------------------------
// spvg_front
// Check a patch request against the configuration and classify it.
// ------------------------------------------------------------------------
`default_nettype none

module spvg_front #(
  parameter int MAX_DIVISIONS = 256
) (
  input  wire logic              in_valid_i,
  input  wire spvg_pkg::in_item_t in_item_i,
  input  wire spvg_pkg::cfg_t    cfg_i,
  input  wire logic              q_full_i,
  output logic                   in_stall_o,
  output logic                   push_o,
  output spvg_pkg::job_t         job_o
);

  logic cfg_bad;
  logic col_bad;
  logic band_bad;

  assign cfg_bad = (cfg_i.radial_divisions == '0) ||
                   (int'(cfg_i.radial_divisions) > MAX_DIVISIONS) ||
                   (cfg_i.height_divisions == '0) ||
                   (int'(cfg_i.height_divisions) > MAX_DIVISIONS);
  assign col_bad = {1'b0, in_item_i.column} >= cfg_i.radial_divisions;
  assign band_bad = (in_item_i.action == spvg_pkg::ACT_MID) &&
                    ((in_item_i.band == '0) ||
                     (({2'b00, in_item_i.band} + 10'd2) > {1'b0, cfg_i.height_divisions}));

  always_comb begin
    job_o.column = in_item_i.column;
    job_o.ring   = '0;
    case (in_item_i.action)
      spvg_pkg::ACT_TOP: begin
        job_o.kind = spvg_pkg::KIND_TOP;
        job_o.ring = cfg_i.height_divisions - 9'd1;
      end
      spvg_pkg::ACT_MID: begin
        job_o.kind = spvg_pkg::KIND_MID;
        job_o.ring = {1'b0, in_item_i.band};
      end
      spvg_pkg::ACT_BOT: begin
        job_o.kind = spvg_pkg::KIND_BOT;
        job_o.ring = 9'd1;
      end
      default: begin
        job_o.kind = spvg_pkg::KIND_ERR;
      end
    endcase
    if (cfg_bad || col_bad || band_bad) begin
      job_o.kind = spvg_pkg::KIND_ERR;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

FILE: src/spvg_queue.sv
// ------------------------------------------------------------------------
// spvg_queue
// Two-entry queue of classified requests between front and back.
// ------------------------------------------------------------------------
`default_nettype none

module spvg_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire spvg_pkg::job_t job_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                valid_o,
  output spvg_pkg::job_t      job_o
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  spvg_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        mem_q[wr_ptr_q] <= job_i;
        wr_ptr_q        <= PTR_W'((int'(wr_ptr_q) + 1) % DEPTH);
      end
      if (do_pop) begin
        rd_ptr_q <= PTR_W'((int'(rd_ptr_q) + 1) % DEPTH);
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/spvg_div.sv
// ------------------------------------------------------------------------
// spvg_div
// Restoring divider, one quotient bit per cycle.
// ------------------------------------------------------------------------
`default_nettype none

module spvg_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spvg_pkg::div_req_t req_i,
  output spvg_pkg::div_rsp_t      rsp_o
);

  localparam int NW  = spvg_pkg::NUM_W;
  localparam int DW  = spvg_pkg::DIVS_W;
  localparam int CW  = $clog2(NW + 1);

  logic [NW-1:0] sr_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_q, sr_q[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        sr_q   <= req_i.num;
        den_q  <= req_i.den;
        rem_q  <= '0;
        cnt_q  <= CW'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // shift in the next numerator bit, subtract when it fits
        sr_q  <= {sr_q[NW-2:0], fits};
        rem_q <= fits ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = sr_q;

endmodule

`default_nettype wire

FILE: src/spvg_back.sv
// ------------------------------------------------------------------------
// spvg_back
// Expand a classified request into vertices and compute each vertex.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spvg_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spvg_pkg::cfg_t     cfg_i,
  input  wire logic               job_valid_i,
  input  wire spvg_pkg::job_t     job_i,
  output logic                    pop_o,
  output spvg_pkg::div_req_t      div_req_o,
  input  wire spvg_pkg::div_rsp_t div_rsp_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output spvg_pkg::out_item_t     out_item_o
);

  localparam int CS_W     = spvg_pkg::CS_W;
  localparam int NW       = spvg_pkg::NUM_W;
  localparam int MAX_STEP = (CORDIC_STEPS > spvg_pkg::SQRT_STEPS) ?
                            CORDIC_STEPS : spvg_pkg::SQRT_STEPS;
  localparam int CNT_W    = $clog2(MAX_STEP + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_DIV_S, ST_DIV_P, ST_DIV_Y, ST_DIV_T,
    ST_SQ, ST_ROT, ST_QUAD, ST_MUL, ST_EMIT
  } state_e;

  state_e                      state_q;
  spvg_pkg::job_t              job_q;
  logic [1:0]                  vidx_q;
  logic [8:0]                  k_q;
  logic [8:0]                  a_q;
  logic                        apex_q;
  logic                        last_q;
  logic [31:0]                 phase_q;
  logic [15:0]                 yh_q;
  logic [31:0]                 rad_q;
  logic [16:0]                 rem_q;
  logic [15:0]                 root_q;
  logic signed [CS_W-1:0]      cx_q, cy_q, cz_q;
  logic signed [CS_W-1:0]      c_q, s_q;
  logic [CNT_W-1:0]            cnt_q;
  spvg_pkg::out_item_t         res_q;
  spvg_pkg::out_item_t         out_q;
  logic                        out_valid_q;
  logic                        out_valid_d;
  logic                        div_start_q;
  logic                        div_start_d;
  logic                        emit_fire;
  logic [NW-1:0]               div_num_q;
  logic [8:0]                  div_den_q;

  // vertex selection
  logic       v_apex, v_last;
  logic [8:0] v_k, v_a;

  // datapath helpers
  logic [24:0]            kd;
  logic [61:0]            zprod;
  logic signed [CS_W-1:0] xs, ys, at, x_n, y_n, z_n;
  logic [18:0]            rem_n, trial;

  function automatic logic [15:0] sat_q88(input logic [15:0] r,
                                          input logic signed [CS_W-1:0] cs);
    logic signed [50:0] p;
    logic signed [20:0] v;
    logic [15:0]        o;
    p = $signed({1'b0, r}) * cs;
    p = p + (51'sd1 <<< 29);
    v = p[50:30];
    if (v > 21'sd32767) begin
      o = 16'h7FFF;
    end else if (v < -21'sd32768) begin
      o = 16'h8000;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

  always_comb begin
    v_apex = 1'b0;
    v_last = 1'b0;
    v_k    = job_q.ring;
    v_a    = {1'b0, job_q.column};
    case (job_q.kind)
      spvg_pkg::KIND_TOP, spvg_pkg::KIND_BOT: begin
        v_apex = (vidx_q == 2'd0);
        v_last = (vidx_q == 2'd2);
        if (vidx_q == 2'd2) v_a = {1'b0, job_q.column} + 9'd1;
      end
      spvg_pkg::KIND_MID: begin
        v_last = (vidx_q == 2'd3);
        if (vidx_q == 2'd1 || vidx_q == 2'd2) v_k = job_q.ring + 9'd1;
        if (vidx_q == 2'd2 || vidx_q == 2'd3) v_a = {1'b0, job_q.column} + 9'd1;
      end
      default: begin
        v_last = 1'b1;
      end
    endcase
  end

  assign kd    = k_q * cfg_i.diameter;
  assign zprod = phase_q[29:0] * spvg_pkg::PI_Q30;

  // one CORDIC rotation
  always_comb begin
    xs = cx_q >>> cnt_q;
    ys = cy_q >>> cnt_q;
    at = $signed({4'b0000, spvg_pkg::atan_q30(cnt_q[4:0])});
    if (!cz_q[CS_W-1]) begin
      x_n = cx_q - ys;
      y_n = cy_q + xs;
      z_n = cz_q - at;
    end else begin
      x_n = cx_q + ys;
      y_n = cy_q - xs;
      z_n = cz_q + at;
    end
  end

  // one square root digit
  assign rem_n = {rem_q, rad_q[31:30]};
  assign trial = {1'b0, root_q, 2'b01};

  assign pop_o = (state_q == ST_IDLE) && job_valid_i;

  // launch a divide on setup of a valid vertex and after each divide but the last
  assign div_start_d = ((state_q == ST_SETUP) && (job_q.kind != spvg_pkg::KIND_ERR)) ||
                       ((state_q == ST_DIV_S) && div_rsp_i.done && !apex_q) ||
                       ((state_q == ST_DIV_P) && div_rsp_i.done) ||
                       ((state_q == ST_DIV_Y) && div_rsp_i.done);

  // hold the output item until taken, load a new one when the slot frees
  assign emit_fire   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign out_valid_d = emit_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
      vidx_q      <= '0;
      cnt_q       <= '0;
    end else begin
      div_start_q <= div_start_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            vidx_q  <= '0;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          k_q    <= v_k;
          a_q    <= v_a;
          apex_q <= v_apex;
          last_q <= v_last;
          if (job_q.kind == spvg_pkg::KIND_ERR) begin
            res_q   <= '{last: 1'b1, error: 1'b1, default: '0};
            state_q <= ST_EMIT;
          end else begin
            div_num_q   <= NW'({v_a, 16'h0000}) + NW'(cfg_i.radial_divisions[8:1]);
            div_den_q   <= cfg_i.radial_divisions;
            state_q     <= ST_DIV_S;
          end
        end
        ST_DIV_S: begin
          if (div_rsp_i.done) begin
            res_q.tex_s <= div_rsp_i.quo[16:0];
            if (apex_q) begin
              res_q.pos_x <= '0;
              res_q.pos_z <= '0;
              res_q.last  <= last_q;
              res_q.error <= 1'b0;
              if (job_q.kind == spvg_pkg::KIND_TOP) begin
                res_q.pos_y <= cfg_i.diameter;
                res_q.tex_t <= spvg_pkg::TEX_ONE;
              end else begin
                res_q.pos_y <= '0;
                res_q.tex_t <= '0;
              end
              state_q <= ST_EMIT;
            end else begin
              div_num_q   <= {a_q, 32'h0} + NW'(cfg_i.radial_divisions[8:1]);
              state_q     <= ST_DIV_P;
            end
          end
        end
        ST_DIV_P: begin
          if (div_rsp_i.done) begin
            phase_q     <= div_rsp_i.quo[31:0];
            div_num_q   <= NW'(kd) + NW'(cfg_i.height_divisions[8:1]);
            div_den_q   <= cfg_i.height_divisions;
            state_q     <= ST_DIV_Y;
          end
        end
        ST_DIV_Y: begin
          if (div_rsp_i.done) begin
            yh_q <= (div_rsp_i.quo > NW'(cfg_i.diameter)) ?
                    cfg_i.diameter : div_rsp_i.quo[15:0];
            div_num_q   <= NW'({k_q, 16'h0000}) + NW'(cfg_i.height_divisions[8:1]);
            state_q     <= ST_DIV_T;
          end
        end
        ST_DIV_T: begin
          if (div_rsp_i.done) begin
            res_q.tex_t <= div_rsp_i.quo[16:0];
            state_q     <= ST_SQ;
          end
        end
        ST_SQ: begin
          rad_q   <= yh_q * (cfg_i.diameter - yh_q);
          rem_q   <= '0;
          root_q  <= '0;
          cx_q    <= spvg_pkg::CORDIC_K;
          cy_q    <= '0;
          cz_q    <= $signed({3'b000, zprod[61:31]});
          cnt_q   <= '0;
          state_q <= ST_ROT;
        end
        ST_ROT: begin
          if (cnt_q < CNT_W'(CORDIC_STEPS)) begin
            cx_q <= x_n;
            cy_q <= y_n;
            cz_q <= z_n;
          end
          if (cnt_q < CNT_W'(spvg_pkg::SQRT_STEPS)) begin
            rad_q <= {rad_q[29:0], 2'b00};
            if (rem_n >= trial) begin
              rem_q  <= 17'(rem_n - trial);
              root_q <= {root_q[14:0], 1'b1};
            end else begin
              rem_q  <= rem_n[16:0];
              root_q <= {root_q[14:0], 1'b0};
            end
          end
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(MAX_STEP - 1)) begin
            state_q <= ST_QUAD;
          end
        end
        ST_QUAD: begin
          case (phase_q[31:30])
            2'd0: begin c_q <= cx_q;  s_q <= cy_q;  end
            2'd1: begin c_q <= -cy_q; s_q <= cx_q;  end
            2'd2: begin c_q <= -cx_q; s_q <= -cy_q; end
            default: begin c_q <= cy_q; s_q <= -cx_q; end
          endcase
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          res_q.pos_x <= sat_q88(root_q, c_q);
          res_q.pos_z <= sat_q88(root_q, s_q);
          res_q.pos_y <= yh_q;
          res_q.last  <= last_q;
          res_q.error <= 1'b0;
          state_q     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_q <= res_q;
            if (res_q.last) begin
              state_q <= ST_IDLE;
            end else begin
              vidx_q  <= vidx_q + 2'd1;
              state_q <= ST_SETUP;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign div_req_o.start = div_start_q;
  assign div_req_o.num   = div_num_q;
  assign div_req_o.den   = div_den_q;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;

  `ASSERT_IMPL(a_err_is_last, clk_i, rst_ni, out_valid_q && out_q.error, out_q.last, "error item without last")
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_q && out_q.error, (out_q.pos_x == '0) && (out_q.pos_y == '0) && (out_q.pos_z == '0) && (out_q.tex_s == '0) && (out_q.tex_t == '0), "error item with vertex data")
  `ASSERT_IMPL(a_div_idle, clk_i, rst_ni, div_start_q, !div_rsp_i.busy, "divider started while busy")

endmodule

`default_nettype wire

FILE: src/sphere_patch_vertex_generator.sv
// Sequence: an error request goes straight to its item without a divide; an apex
//   vertex runs one divide, a ring vertex four divides, then the root and CORDIC
//   setup, max(16, CORDIC_STEPS) rotation/root steps, quadrant and multiply.
// The back pops a request only when idle, once the last item of the one before is loaded.
// Reset: asynchronous, active low; clears the queue, handshakes and restores the
//   registers to diameter 256, 16 radial and 16 height divisions.
// ------------------------------------------------------------------------
// sphere_patch_vertex_generator
// Emits the textured vertices of one patch of a UV sphere resting on the floor.
// ------------------------------------------------------------------------
`default_nettype none

module sphere_patch_vertex_generator #(
  parameter int MAX_DIVISIONS = 256,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire spvg_pkg::in_item_t                in_item_i,
  // vertex channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output spvg_pkg::out_item_t                    out_item_o,
  // register writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [spvg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [spvg_pkg::DIAM_W-1:0]       cfg_data_i
);

  spvg_pkg::cfg_t     cfg_q;
  logic               q_full;
  logic               q_valid;
  logic               push;
  logic               pop;
  spvg_pkg::job_t     front_job;
  spvg_pkg::job_t     queue_job;
  spvg_pkg::div_req_t div_req;
  spvg_pkg::div_rsp_t div_rsp;

  // Registers take a write in any cycle; writes are to be made only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diameter         <= spvg_pkg::DIAMETER_RST;
      cfg_q.radial_divisions <= spvg_pkg::RADIAL_RST;
      cfg_q.height_divisions <= spvg_pkg::HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        spvg_pkg::CFG_DIAMETER: cfg_q.diameter         <= cfg_data_i;
        spvg_pkg::CFG_RADIAL:   cfg_q.radial_divisions <= cfg_data_i[8:0];
        spvg_pkg::CFG_HEIGHT:   cfg_q.height_divisions <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Front: validate the request and pick the ring it starts from.
  spvg_front #(
    .MAX_DIVISIONS(MAX_DIVISIONS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .in_stall_o(in_stall_o),
    .push_o    (push),
    .job_o     (front_job)
  );

  // Queue: lets the front keep accepting while the back computes.
  spvg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .job_o  (queue_job)
  );

  // Shared divider for heights, texture coordinates and phase.
  spvg_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Back: expand into 3 or 4 vertices (one error item for a bad request), run root and CORDIC, hold the result.
  spvg_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(q_valid),
    .job_i      (queue_job),
    .pop_o      (pop),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
